// File: rtl/core/spm_pkg.sv
// spm_pkg: shared constants, codes, payload structs and helpers of the
// symmetry plane point mirror; used by every module of the block
// no dependencies
package spm_pkg;

  // sizing
  localparam int unsigned MaxPoints  = 1024;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CoordEff   = (CoordWidth > 32) ? 32 : CoordWidth;
  localparam int unsigned CoordShift = 32 - CoordEff;
  localparam int unsigned CntWidth   = $clog2(MaxPoints + 1);
  localparam int unsigned IdxWidth   = 11;
  localparam int unsigned SrcWidth   = 10;
  localparam logic [IdxWidth-1:0] IdxMax = '1;

  // decoupling queue between front and back end
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgAxisSelect = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTolerance = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBufferDist = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPointCount = 3'd4;

  typedef enum logic [1:0] {
    AxisNone = 2'd0,
    AxisX    = 2'd1,
    AxisY    = 2'd2,
    AxisZ    = 2'd3
  } axis_e;

  typedef enum logic [1:0] {
    SideNone = 2'd0,
    SidePos  = 2'd1,
    SideNeg  = 2'd2,
    SideBoth = 2'd3
  } side_e;

  // input transaction
  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [IdxWidth-1:0] point_index;
    logic signed [31:0]  out_x;
    logic signed [31:0]  out_y;
    logic signed [31:0]  out_z;
    logic                is_mirror;
    logic [SrcWidth-1:0] source_index;
    logic [1:0]          side_status;
    logic                count_overflow;
    logic                last_of_run;
  } out_item_t;

  // classified point as handed from front to back end
  typedef struct packed {
    in_item_t            coord;
    logic [IdxWidth-1:0] idx;
    logic                full;
    logic                refl;
    axis_e               axis;
    logic signed [31:0]  mirror_val;
    logic [IdxWidth-1:0] mirror_idx;
    logic                mirror_ovf;
    side_e               side;
  } spm_entry_t;

  // take a coordinate as two's complement from its low CoordEff bits
  function automatic logic signed [31:0] sext_coord(input logic [31:0] raw);
    logic [31:0] shl;
    shl = raw << CoordShift;
    return $signed(shl) >>> CoordShift;
  endfunction

endpackage

// File: rtl/core/spm_front.sv
// spm_front: configuration registers, distance stage and classification of
// each point (side fold, counters, mirror value); pushes into the queue
// depends on spm_pkg
module spm_front import spm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output spm_entry_t          push_data_o
);

  localparam int unsigned SumW = ((CntWidth > IdxWidth) ? CntWidth : IdxWidth) + 1;
  localparam logic signed [33:0] SatHi = (34'sd1 <<< (CoordEff - 1)) - 34'sd1;
  localparam logic signed [33:0] SatLo = -(34'sd1 <<< (CoordEff - 1));

  function automatic side_e fold_side(input side_e cur, input side_e s);
    unique case (cur)
      SideNone: return s;
      SidePos:  return (s == SideNeg) ? SideBoth : SidePos;
      SideNeg:  return (s == SidePos) ? SideBoth : SideNeg;
      SideBoth: return SideBoth;
    endcase
  endfunction

  // configuration registers
  axis_e              axis_q;
  logic signed [31:0] offset_q;
  logic [30:0]        tol_q;
  logic [30:0]        buf_q;
  logic [IdxWidth-1:0] pcount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AxisNone;
      offset_q <= '0;
      tol_q    <= '0;
      buf_q    <= '0;
      pcount_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAxisSelect:  axis_q   <= axis_e'(cfg_data_i[1:0]);
        CfgPlaneOffset: offset_q <= cfg_data_i;
        CfgTolerance:   tol_q    <= cfg_data_i[30:0];
        CfgBufferDist:  buf_q    <= cfg_data_i[30:0];
        CfgPointCount:  pcount_q <= cfg_data_i[IdxWidth-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: distance to the plane and raw mirror coordinate
  in_item_t           coord_d;
  logic signed [31:0] axial;
  logic [32:0]        diff;
  logic [32:0]        ndiff;
  logic [32:0]        dist_d;
  logic [33:0]        mirror_d;
  logic [31:0]        band_d;

  assign coord_d.coord_x = sext_coord(in_data_i.coord_x);
  assign coord_d.coord_y = sext_coord(in_data_i.coord_y);
  assign coord_d.coord_z = sext_coord(in_data_i.coord_z);

  always_comb begin
    unique case (axis_q)
      AxisNone: axial = coord_d.coord_x;
      AxisX:    axial = coord_d.coord_x;
      AxisY:    axial = coord_d.coord_y;
      AxisZ:    axial = coord_d.coord_z;
    endcase
  end

  assign diff     = {axial[31], axial} - {offset_q[31], offset_q};
  assign ndiff    = {offset_q[31], offset_q} - {axial[31], axial};
  assign dist_d   = diff[32] ? ndiff : diff;
  assign mirror_d = {offset_q[31], offset_q, 1'b0} - {{2{axial[31]}}, axial};
  assign band_d   = {1'b0, tol_q} + {1'b0, buf_q};

  logic               s1_valid_q;
  in_item_t           s1_coord_q;
  logic [32:0]        s1_dist_q;
  logic               s1_neg_q;
  logic signed [33:0] s1_mirror_q;
  logic [31:0]        s1_band_q;
  logic               accept;

  assign in_ready_o = !s1_valid_q || !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_coord_q  <= coord_d;
      s1_dist_q   <= dist_d;
      s1_neg_q    <= diff[32];
      s1_mirror_q <= $signed(mirror_d);
      s1_band_q   <= band_d;
    end
  end

  // stage 2: on-plane and band compares, side fold
  logic  active;
  logic  on_plane;
  logic  near;
  logic  refl;
  side_e side_sample;
  side_e side_q;
  side_e side_d;

  assign active      = (axis_q != AxisNone);
  assign on_plane    = s1_dist_q < {2'b00, tol_q};
  assign near        = s1_dist_q <= {1'b0, s1_band_q};
  assign refl        = active && !on_plane && near;
  assign side_sample = on_plane ? SideNone : (s1_neg_q ? SideNeg : SidePos);
  assign side_d      = active ? fold_side(side_q, side_sample) : side_q;

  // point and mirror counters with saturation
  logic [CntWidth-1:0] orig_cnt_q;
  logic [CntWidth-1:0] mirr_cnt_q;
  logic                full;
  logic                mfull;
  logic [IdxWidth-1:0] idx;
  logic [CntWidth-1:0] mc;
  logic [SumW-1:0]     sum;
  logic                sovf;

  assign full  = orig_cnt_q >= CntWidth'(MaxPoints);
  assign mfull = mirr_cnt_q >= CntWidth'(MaxPoints);
  assign idx   = full ? IdxWidth'(MaxPoints - 1) : IdxWidth'(orig_cnt_q);
  assign mc    = mfull ? CntWidth'(MaxPoints - 1) : mirr_cnt_q;
  assign sum   = SumW'(pcount_q) + SumW'(mc);
  assign sovf  = sum > SumW'(IdxMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orig_cnt_q <= '0;
      mirr_cnt_q <= '0;
      side_q     <= SideNone;
    end else if (push_o) begin
      side_q <= side_d;
      if (!full) begin
        orig_cnt_q <= orig_cnt_q + CntWidth'(1);
      end
      if (refl && !mfull) begin
        mirr_cnt_q <= mirr_cnt_q + CntWidth'(1);
      end
    end
  end

  // saturated mirror coordinate
  logic [31:0] mirror_val;

  always_comb begin
    priority if (s1_mirror_q > SatHi) begin
      mirror_val = SatHi[31:0];
    end else if (s1_mirror_q < SatLo) begin
      mirror_val = SatLo[31:0];
    end else begin
      mirror_val = s1_mirror_q[31:0];
    end
  end

  // queue entry
  always_comb begin
    push_data_o.coord      = s1_coord_q;
    push_data_o.idx        = idx;
    push_data_o.full       = full;
    push_data_o.refl       = refl;
    push_data_o.axis       = axis_q;
    push_data_o.mirror_val = mirror_val;
    push_data_o.mirror_idx = sovf ? IdxMax : sum[IdxWidth-1:0];
    push_data_o.mirror_ovf = full || mfull || sovf;
    push_data_o.side       = side_d;
  end

endmodule

// File: rtl/core/spm_queue.sv
// spm_queue: short queue of classified points between front and back end
// depends on spm_pkg
module spm_queue import spm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  spm_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output spm_entry_t head_o
);

  spm_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/spm_back.sv
// spm_back: turns each queued point into its result transactions, the
// original and, where flagged, the mirror copy, through an output register
// depends on spm_pkg
module spm_back import spm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  spm_entry_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  logic      out_valid_q;
  out_item_t out_q;
  logic      phase_q;
  logic      load_en;
  logic      take;
  out_item_t orig_res;
  out_item_t mirr_res;

  assign load_en     = !out_valid_q || out_ready_i;
  assign take        = load_en && head_valid_i;
  assign pop_o       = take && (phase_q || !head_i.refl);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // original point result
  always_comb begin
    orig_res.point_index    = head_i.idx;
    orig_res.out_x          = head_i.coord.coord_x;
    orig_res.out_y          = head_i.coord.coord_y;
    orig_res.out_z          = head_i.coord.coord_z;
    orig_res.is_mirror      = 1'b0;
    orig_res.source_index   = head_i.idx[SrcWidth-1:0];
    orig_res.side_status    = head_i.side;
    orig_res.count_overflow = head_i.full;
    orig_res.last_of_run    = !head_i.refl;
  end

  // mirror result, chosen coordinate replaced
  always_comb begin
    mirr_res                = orig_res;
    mirr_res.point_index    = head_i.mirror_idx;
    mirr_res.is_mirror      = 1'b1;
    mirr_res.count_overflow = head_i.mirror_ovf;
    mirr_res.last_of_run    = 1'b1;
    unique case (head_i.axis)
      AxisNone: ;
      AxisX:    mirr_res.out_x = head_i.mirror_val;
      AxisY:    mirr_res.out_y = head_i.mirror_val;
      AxisZ:    mirr_res.out_z = head_i.mirror_val;
    endcase
  end

  // output valid and result phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load_en) begin
        out_valid_q <= head_valid_i;
      end
      if (take) begin
        phase_q <= !phase_q && head_i.refl;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= phase_q ? mirr_res : orig_res;
    end
  end

endmodule

// File: rtl/core/symmetry_plane_point_mirror.sv
// Symmetry plane point mirror. Accepts one signed Q16.16 point per cycle and
// emits it with its running index; when a plane axis is set and the point lies
// off the plane but inside the mirror band, a reflected copy follows as a
// second transaction. A point is taken every cycle as long as results drain:
// the output register hands out one result per cycle, so a stream of points
// that all reflect is held back by the two results each point needs. Each
// point passes the distance stage, classification into the four-entry
// queue and the output register. Configuration is taken any cycle but
// must only be written while no points are in flight.
// depends on spm_pkg, spm_front, spm_queue, spm_back
module symmetry_plane_point_mirror import spm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  logic       push;
  spm_entry_t push_data;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  spm_entry_t head;

  // classification front end
  spm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // decoupling queue
  spm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  // result back end
  spm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: rtl/core/spm_checker.sv
// spm_checker: port-level assertions on the point mirror output stream,
// attached to the top level by bind
// depends on spm_pkg and symmetry_plane_point_mirror
module spm_checker import spm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // a mirror is always the final result of its point
  a_mirror_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_mirror |-> out_data_o.last_of_run)
    else $error("mirror result not marked last");

  // an original carries its own index as source
  a_orig_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_mirror |->
      out_data_o.source_index == out_data_o.point_index[SrcWidth-1:0])
    else $error("original result source index mismatch");

  // a non-final original is directly followed by its mirror
  a_mirror_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_valid_o && out_data_o.is_mirror &&
      out_data_o.source_index == $past(out_data_o.source_index) &&
      out_data_o.side_status == $past(out_data_o.side_status))
    else $error("mirror result missing after original");

endmodule

bind symmetry_plane_point_mirror spm_checker u_spm_checker (.*);
